FILE: rtl/core/vau_pkg.sv
`timescale 1ns / 1ps
// Shared types and action codes of the vector arithmetic unit.
package vau_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 2 * DATA_W;

    typedef enum logic [3:0] {
        ACT_ADD       = 4'd0,
        ACT_SUB       = 4'd1,
        ACT_SCALE     = 4'd2,
        ACT_DIVIDE    = 4'd3,
        ACT_DOT       = 4'd4,
        ACT_CROSS     = 4'd5,
        ACT_LENGTH    = 4'd6,
        ACT_NORMALIZE = 4'd7,
        ACT_EQUAL     = 4'd8
    } t_action;

    typedef struct packed {
        logic [3:0]               action;
        logic signed [DATA_W-1:0] ax;
        logic signed [DATA_W-1:0] ay;
        logic signed [DATA_W-1:0] az;
        logic signed [DATA_W-1:0] bx;
        logic signed [DATA_W-1:0] by;
        logic signed [DATA_W-1:0] bz;
        logic signed [DATA_W-1:0] scalar_in;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] rx;
        logic signed [DATA_W-1:0] ry;
        logic signed [DATA_W-1:0] rz;
        logic signed [DATA_W-1:0] scalar_out;
        logic                     is_equal;
        logic                     overflow;
        logic                     div_zero;
    } t_out;

    typedef struct packed {
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] q;
        logic signed [DATA_W:0]   addsub;
    } t_lane_prod;

endpackage

FILE: rtl/core/vector3_arithmetic_unit.sv
`timescale 1ns / 1ps
// Three-component vector ALU on signed fixed point with FRAC_BITS fraction bits
// (Q16.16 for the default of 16). The unit is fully pipelined: it takes a new item
// in every cycle, busy stays low except during reset and in the cycle after it, and
// each result appears on o_result with o_valid for one cycle. Every item passes
// through the 32-stage square root followed by the 32 + FRAC_BITS stage divider,
// so that results leave in order. The receiver cannot stall; there is no storage
// to clear after reset.
module vector3_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  vau_pkg::t_in   i_item,
    output logic           busy,
    output logic           o_valid,
    output vau_pkg::t_out  o_result
);

    localparam int NB       = 32 + FRAC_BITS;
    localparam int SQ_STEPS = 32;

    localparam logic [31:0]        MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0]        MIN_NEG = 32'h8000_0000;
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef struct packed {
        logic [3:0]       action;
        logic [2:0][31:0] a;
        logic [31:0]      s;
        logic             eq;
    } t_s1;

    typedef struct packed {
        logic [3:0]       action;
        logic [2:0][31:0] a;
        logic [31:0]      s;
        logic [2:0][31:0] r;
        logic [31:0]      sc;
        logic             eq;
        logic             ovf;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic [31:0] root;
    } t_side2;

    function automatic logic [32:0] sat_66(input logic signed [65:0] v);
        if (v > SAT_MAX) begin
            sat_66 = {1'b1, MAX_POS};
        end else if (v < SAT_MIN) begin
            sat_66 = {1'b1, MIN_NEG};
        end else begin
            sat_66 = {1'b0, v[31:0]};
        end
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // Input register.
    logic          r_busy;
    logic          r_v0;
    vau_pkg::t_in  r_in;
    logic          r_v1;
    t_s1           r_s1;
    logic          r_v2;
    t_side         r_s2;
    logic [63:0]   r_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_v0   <= start && !r_busy;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
        end
        r_in <= i_item;
    end

    assign busy = r_busy;

    // Component lanes.
    logic signed [31:0]  w_a [3];
    logic signed [31:0]  w_b [3];
    vau_pkg::t_lane_prod w_prod [3];

    assign w_a[0] = r_in.ax;
    assign w_a[1] = r_in.ay;
    assign w_a[2] = r_in.az;
    assign w_b[0] = r_in.bx;
    assign w_b[1] = r_in.by;
    assign w_b[2] = r_in.bz;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        vau_mul_lane u_lane (
            .i_clk    (i_clk),
            .i_action (r_in.action),
            .i_a_self (w_a[i]),
            .i_a_next (w_a[(i + 1) % 3]),
            .i_a_prev (w_a[(i + 2) % 3]),
            .i_b_self (w_b[i]),
            .i_b_next (w_b[(i + 1) % 3]),
            .i_b_prev (w_b[(i + 2) % 3]),
            .i_scalar (r_in.scalar_in),
            .o_prod   (w_prod[i])
        );
    end

    always_ff @(posedge i_clk) begin
        r_s1.action <= r_in.action;
        r_s1.a      <= {r_in.az, r_in.ay, r_in.ax};
        r_s1.s      <= r_in.scalar_in;
        r_s1.eq     <= (r_in.action == vau_pkg::ACT_EQUAL) && (r_in.ax == r_in.bx)
                       && (r_in.ay == r_in.by) && (r_in.az == r_in.bz);
    end

    // Merge stage: the dot product sums the three lanes, others finish per lane.
    t_side              n_s2;
    logic signed [65:0] n_dot;
    logic signed [65:0] n_lane_v [3];
    logic [32:0]        n_sat_lane [3];
    logic [32:0]        n_sat_dot;

    always_comb begin
        n_dot = 66'(w_prod[0].p) + 66'(w_prod[1].p) + 66'(w_prod[2].p);
        n_sat_dot = sat_66(n_dot >>> FRAC_BITS);
        n_s2.action = r_s1.action;
        n_s2.a      = r_s1.a;
        n_s2.s      = r_s1.s;
        n_s2.eq     = r_s1.eq;
        n_s2.sc     = '0;
        n_s2.ovf    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_lane_v[i] = (r_s1.action == vau_pkg::ACT_CROSS)
                        ? 66'(w_prod[i].p) - 66'(w_prod[i].q) : 66'(w_prod[i].p);
            n_sat_lane[i] = '0;
            n_s2.r[i] = '0;
            case (r_s1.action)
                vau_pkg::ACT_ADD, vau_pkg::ACT_SUB: begin
                    n_sat_lane[i] = sat_66(66'(w_prod[i].addsub));
                    n_s2.r[i] = n_sat_lane[i][31:0];
                    n_s2.ovf = n_s2.ovf | n_sat_lane[i][32];
                end
                vau_pkg::ACT_SCALE, vau_pkg::ACT_CROSS: begin
                    n_sat_lane[i] = sat_66(n_lane_v[i] >>> FRAC_BITS);
                    n_s2.r[i] = n_sat_lane[i][31:0];
                    n_s2.ovf = n_s2.ovf | n_sat_lane[i][32];
                end
                vau_pkg::ACT_NORMALIZE: n_s2.r[i] = r_s1.a[i];
                default: n_s2.r[i] = '0;
            endcase
        end
        if (r_s1.action == vau_pkg::ACT_DOT) begin
            n_s2.sc  = n_sat_dot[31:0];
            n_s2.ovf = n_sat_dot[32];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2  <= n_s2;
        r_rad <= n_dot[63:0];
    end

    // Square root, with the item's other fields carried alongside.
    logic [31:0]         w_root;
    t_side               r_sd1 [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_vq;

    vau_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq <= '0;
        end else begin
            r_vq <= {r_vq[SQ_STEPS-2:0], r_v2};
        end
        r_sd1[0] <= r_s2;
        for (int k = 1; k < SQ_STEPS; k++) begin
            r_sd1[k] <= r_sd1[k-1];
        end
    end

    // Divider lanes: divide uses |scalar|, normalize uses the length.
    t_side           w_sq_side;
    logic [31:0]     w_den;
    logic [NB-1:0]   w_quot [3];
    t_side2          r_sd2 [NB];
    logic [NB-1:0]   r_vd;

    assign w_sq_side = r_sd1[SQ_STEPS-1];
    assign w_den = (w_sq_side.action == vau_pkg::ACT_NORMALIZE) ? w_root : abs32(w_sq_side.s);

    for (genvar i = 0; i < 3; i++) begin : g_div
        vau_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk  (i_clk),
            .i_num  (abs32(w_sq_side.a[i])),
            .i_den  (w_den),
            .o_quot (w_quot[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else begin
            r_vd <= {r_vd[NB-2:0], r_vq[SQ_STEPS-1]};
        end
        r_sd2[0] <= '{side: w_sq_side, root: w_root};
        for (int k = 1; k < NB; k++) begin
            r_sd2[k] <= r_sd2[k-1];
        end
    end

    // Final stage: sign, saturation and the special cases.
    t_side2             w_fin;
    vau_pkg::t_out      n_out;
    logic signed [NB:0] n_qs [3];
    logic [32:0]        n_sat_q [3];
    logic               n_neg;
    vau_pkg::t_out      r_out;
    logic               r_valid;

    assign w_fin = r_sd2[NB-1];

    always_comb begin
        n_out.rx         = w_fin.side.r[0];
        n_out.ry         = w_fin.side.r[1];
        n_out.rz         = w_fin.side.r[2];
        n_out.scalar_out = w_fin.side.sc;
        n_out.is_equal   = w_fin.side.eq;
        n_out.overflow   = w_fin.side.ovf;
        n_out.div_zero   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_neg = w_fin.side.a[i][31]
                  ^ ((w_fin.side.action == vau_pkg::ACT_DIVIDE) & w_fin.side.s[31]);
            n_qs[i] = n_neg ? -$signed({1'b0, w_quot[i]}) : $signed({1'b0, w_quot[i]});
            n_sat_q[i] = sat_66(66'(n_qs[i]));
        end
        case (w_fin.side.action)
            vau_pkg::ACT_DIVIDE: begin
                if (w_fin.side.s == '0) begin
                    // Zero divisor: each nonzero component goes to the rail of its own sign, a zero one stays zero.
                    n_out.div_zero = 1'b1;
                    n_out.rx = w_fin.side.a[0][31] ? MIN_NEG : ((|w_fin.side.a[0]) ? MAX_POS : '0);
                    n_out.ry = w_fin.side.a[1][31] ? MIN_NEG : ((|w_fin.side.a[1]) ? MAX_POS : '0);
                    n_out.rz = w_fin.side.a[2][31] ? MIN_NEG : ((|w_fin.side.a[2]) ? MAX_POS : '0);
                end else begin
                    n_out.rx = n_sat_q[0][31:0];
                    n_out.ry = n_sat_q[1][31:0];
                    n_out.rz = n_sat_q[2][31:0];
                    n_out.overflow = n_sat_q[0][32] | n_sat_q[1][32] | n_sat_q[2][32];
                end
            end
            vau_pkg::ACT_NORMALIZE: begin
                // A zero-length vector keeps the copy of a made in the merge stage.
                if (w_fin.root != '0) begin
                    n_out.rx = n_qs[0][31:0];
                    n_out.ry = n_qs[1][31:0];
                    n_out.rz = n_qs[2][31:0];
                end
            end
            vau_pkg::ACT_LENGTH: begin
                n_out.scalar_out = w_fin.root[31] ? MAX_POS : w_fin.root;
                n_out.overflow   = w_fin.root[31];
            end
            default: n_out.div_zero = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vd[NB-1];
        end
        r_out <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

FILE: rtl/core/vau_mul_lane.sv
`timescale 1ns / 1ps
// One component lane: operand selection, two products and the add or subtract.
module vau_mul_lane (
    input  logic                     i_clk,
    input  logic [3:0]               i_action,
    input  logic signed [31:0]       i_a_self,
    input  logic signed [31:0]       i_a_next,
    input  logic signed [31:0]       i_a_prev,
    input  logic signed [31:0]       i_b_self,
    input  logic signed [31:0]       i_b_next,
    input  logic signed [31:0]       i_b_prev,
    input  logic signed [31:0]       i_scalar,
    output vau_pkg::t_lane_prod      o_prod
);

    logic signed [31:0] n_x;
    logic signed [31:0] n_y;
    logic signed [63:0] n_p;
    logic signed [63:0] n_q;
    logic signed [32:0] n_addsub;
    vau_pkg::t_lane_prod r_prod;

    // For the cross product this lane forms a_next*b_prev and a_prev*b_next; the merge stage subtracts them.
    always_comb begin
        n_x = i_a_self;
        n_y = '0;
        case (i_action)
            vau_pkg::ACT_SCALE: n_y = i_scalar;
            vau_pkg::ACT_DOT:   n_y = i_b_self;
            vau_pkg::ACT_CROSS: begin
                n_x = i_a_next;
                n_y = i_b_prev;
            end
            vau_pkg::ACT_LENGTH, vau_pkg::ACT_NORMALIZE: n_y = i_a_self;
            default: n_y = '0;
        endcase
    end

    assign n_p = n_x * n_y;
    assign n_q = i_a_prev * i_b_next;
    assign n_addsub = (i_action == vau_pkg::ACT_SUB)
                    ? $signed({i_a_self[31], i_a_self} - {i_b_self[31], i_b_self})
                    : $signed({i_a_self[31], i_a_self} + {i_b_self[31], i_b_self});

    always_ff @(posedge i_clk) begin
        r_prod.p      <= n_p;
        r_prod.q      <= n_q;
        r_prod.addsub <= n_addsub;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/core/vau_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root of a 64-bit value, one root bit per stage.
module vau_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    localparam int STEPS = 32;

    logic [35:0] r_rem  [1:STEPS-1];
    logic [63:0] r_rad  [1:STEPS-1];
    logic [31:0] r_root [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [35:0] n_rem_in;
        logic [63:0] n_rad_in;
        logic [31:0] n_root_in;
        logic [35:0] n_cur;
        logic [35:0] n_trial;
        logic        n_ge;

        if (k == 0) begin : g_first
            assign n_rem_in  = '0;
            assign n_rad_in  = i_rad;
            assign n_root_in = '0;
        end else begin : g_next
            assign n_rem_in  = r_rem[k];
            assign n_rad_in  = r_rad[k];
            assign n_root_in = r_root[k];
        end

        assign n_cur   = {n_rem_in[33:0], n_rad_in[63:62]};
        assign n_trial = {2'b00, n_root_in, 2'b01};
        assign n_ge    = (n_cur >= n_trial);

        always_ff @(posedge i_clk) begin
            r_root[k+1] <= {n_root_in[30:0], n_ge};
        end

        if (k < STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= n_ge ? (n_cur - n_trial) : n_cur;
                r_rad[k+1] <= {n_rad_in[61:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[STEPS];

endmodule

FILE: rtl/core/vau_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: (num * 2^FRAC_BITS) / den, one quotient bit per stage.
module vau_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic [31:0]             i_num,
    input  logic [31:0]             i_den,
    output logic [32+FRAC_BITS-1:0] o_quot
);

    localparam int NB = 32 + FRAC_BITS;

    logic [31:0]   r_rem  [1:NB-1];
    logic [NB-1:0] r_num  [1:NB-1];
    logic [31:0]   r_den  [1:NB-1];
    logic [NB-1:0] r_quot [1:NB];

    for (genvar k = 0; k < NB; k++) begin : g_step
        logic [31:0]   n_rem_in;
        logic [NB-1:0] n_num_in;
        logic [31:0]   n_den_in;
        logic [NB-1:0] n_quot_in;
        logic [32:0]   n_cur;
        logic [32:0]   n_diff;
        logic          n_ge;

        if (k == 0) begin : g_first
            assign n_rem_in  = '0;
            assign n_num_in  = {i_num, {FRAC_BITS{1'b0}}};
            assign n_den_in  = i_den;
            assign n_quot_in = '0;
        end else begin : g_next
            assign n_rem_in  = r_rem[k];
            assign n_num_in  = r_num[k];
            assign n_den_in  = r_den[k];
            assign n_quot_in = r_quot[k];
        end

        assign n_cur  = {n_rem_in, n_num_in[NB-1]};
        assign n_diff = n_cur - {1'b0, n_den_in};
        assign n_ge   = (n_cur >= {1'b0, n_den_in});

        always_ff @(posedge i_clk) begin
            r_quot[k+1] <= {n_quot_in[NB-2:0], n_ge};
        end

        if (k < NB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k+1] <= n_ge ? n_diff[31:0] : n_cur[31:0];
                r_num[k+1] <= {n_num_in[NB-2:0], 1'b0};
                r_den[k+1] <= n_den_in;
            end
        end
    end

    assign o_quot = r_quot[NB];

endmodule

FILE: rtl/core/vau_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the vector arithmetic unit and their binding to the top level.
module vau_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input vau_pkg::t_out o_result
);

    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && start |-> !busy)
        else $error("busy high outside reset recovery");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_div_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.div_zero |->
            !o_result.overflow && !o_result.is_equal && o_result.scalar_out == '0)
        else $error("zero divisor item carries other flags");

    a_equal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.is_equal |->
            o_result.rx == '0 && o_result.ry == '0 && o_result.rz == '0
            && o_result.scalar_out == '0 && !o_result.overflow)
        else $error("equality item carries arithmetic results");

endmodule

bind vector3_arithmetic_unit vau_checker u_vau_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the three-component fixed-point vector unit.
module tb_top;
    import vau_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 68 + FRAC;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_in i_item = '0;
    logic busy;
    logic o_valid;
    t_out o_result;

    t_out pending_results[$];
    int error_count = 0;
    int cycle_count = 0;

    typedef struct {
        t_in  stim;
        bit   typed;
        t_out want;
    } t_row;

    vector3_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_valid(o_valid), .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [31:0] clamp(input logic signed [127:0] v, inout bit ovf);
        if (v > 128'(MAXV)) begin
            ovf = 1'b1;
            return MAXV;
        end
        if (v < 128'(MINV)) begin
            ovf = 1'b1;
            return MINV;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] one_bit;
        res = '0;
        for (int i = 31; i >= 0; i--) begin
            one_bit = 64'd1 << (2 * i);
            if (v >= res + one_bit) begin
                v = v - (res + one_bit);
                res = (res >> 1) + one_bit;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // Fixed-point quotient, truncated toward zero.
    function automatic logic signed [127:0] quotient(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
        logic signed [127:0] un;
        logic signed [127:0] ud;
        logic signed [127:0] q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un <<< FRAC) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic t_out vector_result(input t_in x);
        t_out r;
        bit ovf;
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] s;
        logic signed [127:0] len;
        r = '0;
        ovf = 1'b0;
        a[0] = x.ax; a[1] = x.ay; a[2] = x.az;
        b[0] = x.bx; b[1] = x.by; b[2] = x.bz;
        s = x.scalar_in;
        case (x.action)
            ACT_ADD: begin
                r.rx = clamp(a[0] + b[0], ovf);
                r.ry = clamp(a[1] + b[1], ovf);
                r.rz = clamp(a[2] + b[2], ovf);
            end
            ACT_SUB: begin
                r.rx = clamp(a[0] - b[0], ovf);
                r.ry = clamp(a[1] - b[1], ovf);
                r.rz = clamp(a[2] - b[2], ovf);
            end
            ACT_SCALE: begin
                r.rx = clamp((a[0] * s) >>> FRAC, ovf);
                r.ry = clamp((a[1] * s) >>> FRAC, ovf);
                r.rz = clamp((a[2] * s) >>> FRAC, ovf);
            end
            ACT_DIVIDE: begin
                if (s == 0) begin
                    // Zero divisor saturates toward the sign of each component; a zero component stays zero.
                    r.div_zero = 1'b1;
                    r.rx = (a[0] > 0) ? MAXV : (a[0] < 0) ? MINV : 32'sd0;
                    r.ry = (a[1] > 0) ? MAXV : (a[1] < 0) ? MINV : 32'sd0;
                    r.rz = (a[2] > 0) ? MAXV : (a[2] < 0) ? MINV : 32'sd0;
                end else begin
                    r.rx = clamp(quotient(a[0], s), ovf);
                    r.ry = clamp(quotient(a[1], s), ovf);
                    r.rz = clamp(quotient(a[2], s), ovf);
                end
            end
            ACT_DOT: r.scalar_out = clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC,
                                          ovf);
            ACT_CROSS: begin
                r.rx = clamp((a[1] * b[2] - a[2] * b[1]) >>> FRAC, ovf);
                r.ry = clamp((a[2] * b[0] - a[0] * b[2]) >>> FRAC, ovf);
                r.rz = clamp((a[0] * b[1] - a[1] * b[0]) >>> FRAC, ovf);
            end
            ACT_LENGTH: begin
                len = {64'd0, root64(64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]))};
                r.scalar_out = clamp(len, ovf);
            end
            ACT_NORMALIZE: begin
                len = {64'd0, root64(64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]))};
                if (len == 0) begin
                    r.rx = x.ax; r.ry = x.ay; r.rz = x.az;
                end else begin
                    r.rx = 32'(quotient(a[0], len));
                    r.ry = 32'(quotient(a[1], len));
                    r.rz = 32'(quotient(a[2], len));
                end
            end
            ACT_EQUAL: r.is_equal = (x.ax == x.bx) && (x.ay == x.by) && (x.az == x.bz);
            default: r = '0;
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report("unexpected result, valid", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.rx !== want.rx) report("rx", o_result.rx, want.rx);
                if (o_result.ry !== want.ry) report("ry", o_result.ry, want.ry);
                if (o_result.rz !== want.rz) report("rz", o_result.rz, want.rz);
                if (o_result.scalar_out !== want.scalar_out)
                    report("scalar_out", o_result.scalar_out, want.scalar_out);
                if (o_result.is_equal !== want.is_equal)
                    report("is_equal", o_result.is_equal, want.is_equal);
                if (o_result.overflow !== want.overflow)
                    report("overflow", o_result.overflow, want.overflow);
                if (o_result.div_zero !== want.div_zero)
                    report("div_zero", o_result.div_zero, want.div_zero);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Holds start high until the unit takes the item, then queues its result.
    task automatic send(input t_in x, input bit typed, input t_out want);
        start <= 1'b1;
        i_item <= x;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(typed ? want : vector_result(x));
    endtask

    task automatic pause_for(input int pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: case ($urandom_range(0, 4))
                   0: return MAXV;
                   1: return MINV;
                   2: return 32'sd0;
                   3: return -32'sd1;
                   default: return ONE;
               endcase
            1: return $signed(32'($urandom_range(0, 2 ** 21))) - (2 ** 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in random_item();
        t_in x;
        x.action = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
        x.ax = pick_value(); x.ay = pick_value(); x.az = pick_value();
        x.bx = pick_value(); x.by = pick_value(); x.bz = pick_value();
        x.scalar_in = ($urandom_range(0, 7) == 0) ? 32'sd0 : pick_value();
        if (x.action == ACT_EQUAL && $urandom_range(0, 1)) begin
            // Often equal vectors, sometimes differing in one component only.
            x.bx = x.ax; x.by = x.ay; x.bz = x.az;
            if ($urandom_range(0, 1)) x.by = x.ay ^ (32'sd1 << $urandom_range(0, 31));
        end
        return x;
    endfunction

    initial begin
        t_row rows[$];
        t_row row;
        int idle_pct[4];
        idle_pct = '{0, 59, 0, 35};

        row.typed = 1'b1;
        row.stim = '{ACT_ADD, MAXV, MINV, ONE, ONE, -32'sd1, ONE, 0};
        row.want = '{MAXV, MINV, 32'sd2 <<< 16, 0, 0, 1, 0};
        rows.push_back(row);
        row.stim = '{ACT_SUB, MINV, MAXV, 0, ONE, -32'sd1, MINV, 0};
        row.want = '{MINV, MAXV, MAXV, 0, 0, 1, 0};
        rows.push_back(row);
        row.stim = '{ACT_DIVIDE, MAXV, MINV, 0, 0, 0, 0, 0};
        row.want = '{MAXV, MINV, 0, 0, 0, 0, 1};
        rows.push_back(row);
        row.stim = '{ACT_NORMALIZE, 0, 0, 0, MAXV, MINV, ONE, ONE};
        row.want = '0;
        rows.push_back(row);
        row.stim = '{ACT_EQUAL, MINV, MAXV, -32'sd1, MINV, MAXV, -32'sd1, MAXV};
        row.want = '{0, 0, 0, 0, 1, 0, 0};
        rows.push_back(row);
        row.stim = '{4'd9, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV};
        row.want = '0;
        rows.push_back(row);
        row.stim = '{4'd15, MINV, MINV, MINV, MINV, MINV, MINV, MINV};
        rows.push_back(row);

        row.typed = 1'b0;
        row.stim = '{ACT_SCALE, MAXV, MINV, -32'sd1, 0, 0, 0, MINV};
        rows.push_back(row);
        row.stim = '{ACT_SCALE, ONE, -ONE, 32'sd3, 0, 0, 0, -32'sd1};
        rows.push_back(row);
        row.stim = '{ACT_DIVIDE, MINV, MAXV, ONE, 0, 0, 0, -32'sd1};
        rows.push_back(row);
        row.stim = '{ACT_DIVIDE, -32'sd7, 32'sd7, MINV, 0, 0, 0, MINV};
        rows.push_back(row);
        row.stim = '{ACT_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0};
        rows.push_back(row);
        row.stim = '{ACT_DOT, -ONE, 32'sd3, ONE, ONE, -32'sd5, 32'sd1, 0};
        rows.push_back(row);
        row.stim = '{ACT_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0};
        rows.push_back(row);
        row.stim = '{ACT_CROSS, ONE, 0, 0, 0, ONE, 0, 0};
        rows.push_back(row);
        row.stim = '{ACT_LENGTH, MINV, MINV, MINV, 0, 0, 0, 0};
        rows.push_back(row);
        row.stim = '{ACT_LENGTH, 32'sd3 <<< 16, 32'sd4 <<< 16, 0, 0, 0, 0, 0};
        rows.push_back(row);
        row.stim = '{ACT_NORMALIZE, MINV, MAXV, 32'sd1, 0, 0, 0, 0};
        rows.push_back(row);
        row.stim = '{ACT_NORMALIZE, 32'sd1, 0, 0, 0, 0, 0, 0};
        rows.push_back(row);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send(rows[i].stim, rows[i].typed, rows[i].want);

        foreach (idle_pct[p]) begin
            // Hold off until the pipeline has drained before each new phase.
            start <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
            for (int n = 0; n < 210; n++) begin
                pause_for(idle_pct[p]);
                send(random_item(), 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/vau_pkg.sv
rtl/core/vau_mul_lane.sv
rtl/core/vau_sqrt.sv
rtl/core/vau_div.sv
rtl/core/vector3_arithmetic_unit.sv
rtl/core/vau_checker.sv
tb/tb_top.sv
